>>> rtl/stereo_fir_filter_with_gain_core_assert.svh
// Assertion macros for the stereo FIR filter RTL.
`ifndef STEREO_FIR_FILTER_WITH_GAIN_CORE_ASSERT_SVH
`define STEREO_FIR_FILTER_WITH_GAIN_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sfg assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sfg assertion failed");

`endif

>>> rtl/sfg_pkg.sv
// Shared types, constants and helpers for the stereo FIR filter with gain.
`default_nettype none

package sfg_pkg;

  localparam int TAPS_DEF        = 25;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int GAIN_W          = 16;
  localparam int GAIN_FRAC       = 13;
  localparam int COEF_IDX_W      = 5;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd8192;

  // Item operation codes.
  localparam logic OP_COEF   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Register index taken from the word address bit.
  localparam logic REG_IDX_GAIN = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SHIFT,
    ST_ROUND,
    ST_GAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic coef_en;
    logic coef_wr;
    logic smp_en;
  } cell_ctrl_t;

  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_en;
    logic rnd_en;
    logic gain_en;
  } mac_ctrl_t;

  // Accumulator width: exact for the whole sum, but never above 64 bits.
  function automatic int acc_width(int sample_bits, int taps);
    int w;
    w = 2 * sample_bits + $clog2(taps);
    return (w > 64) ? 64 : w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/stereo_fir_filter_with_gain_core.sv
// Top level of the stereo FIR filter with output gain.
`default_nettype none

// Two-channel FIR filter with a shared coefficient set and a programmable output gain.
// A transaction with op 0 writes one coefficient and returns nothing; indexes at or
// above TAPS are dropped. A transaction with op 1 carries a left and a right sample
// and returns one filtered pair. The taps sit in a ring of TAPS identical cells; for
// a sample transaction the ring rotates once, and at each step the cell at its head
// feeds one multiplier per channel. A shift step then moves the histories along by
// one sample, a round step and a gain step follow, and the result saturates on its
// way into the output register, where it sits, so a following transaction is
// accepted while the previous result waits to be taken.
// The gain register is at byte address 0 of the APB port, unsigned Q3.13, resetting
// to 1.0; write it only while no transaction is in progress.

module stereo_fir_filter_with_gain_core
  import sfg_pkg::*;
#(
  parameter int TAPS        = TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input channel.
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          op_i,
  input  wire logic        [COEF_IDX_W-1:0]  coef_index_i,
  input  wire logic signed [SAMPLE_BITS-1:0] coef_value_i,
  input  wire logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0] right_sample_i,
  // Output channel.
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]      left_out_o,
  output logic signed [SAMPLE_BITS-1:0]      right_out_o,
  // Configuration port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic        [PADDR_W-1:0]     paddr,
  input  wire logic        [PDATA_W-1:0]     pwdata,
  output logic             [PDATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int CntW = $clog2(TAPS);

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [GAIN_W-1:0] gain_q;
  logic out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] left_out_q, right_out_q;

  logic accept;
  logic coef_we;
  logic load;
  logic rotate;
  logic hshift;
  logic out_load;
  logic last_step;
  mac_ctrl_t mac_ctrl;

  logic signed [SAMPLE_BITS-1:0] coef_w  [TAPS];
  logic signed [SAMPLE_BITS-1:0] left_w  [TAPS];
  logic signed [SAMPLE_BITS-1:0] right_w [TAPS];
  logic signed [SAMPLE_BITS-1:0] left_res, right_res;

  // ---------------------------------------------------------------------------
  // Configuration register. Only the word address bit selects a register, so
  // writes to any other word are ignored and read back as zero.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[PADDR_W-1] == REG_IDX_GAIN)) begin
      gain_q <= pwdata[GAIN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1] == REG_IDX_GAIN) begin
      prdata = {{(PDATA_W-GAIN_W){1'b0}}, gain_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------------
  assign last_step = (cnt_q == CntW'(TAPS - 1));

  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (op_i == OP_SAMPLE)) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (last_step) begin
          state_d = ST_SHIFT;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_SHIFT: state_d = ST_ROUND;
      ST_ROUND: state_d = ST_GAIN;
      ST_GAIN:  state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs.
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready_o       = (state_q == ST_IDLE);
    accept           = in_valid_i && in_ready_o;
    coef_we          = accept && (op_i == OP_COEF) && (32'(coef_index_i) < 32'(TAPS));
    load             = accept && (op_i == OP_SAMPLE);
    rotate           = (state_q == ST_MAC);
    hshift           = (state_q == ST_SHIFT);
    out_load         = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
    mac_ctrl.mul_en  = rotate;
    mac_ctrl.acc_clr = load;
    // The product register sits between the ring and the accumulator, so the last product
    // is added while the histories shift.
    mac_ctrl.acc_en  = (rotate && (cnt_q != '0)) || hshift;
    mac_ctrl.rnd_en  = (state_q == ST_ROUND);
    mac_ctrl.gain_en = (state_q == ST_GAIN);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      left_out_q  <= left_res;
      right_out_q <= right_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

  // ---------------------------------------------------------------------------
  // Ring of tap cells. Cell 0 holds the oldest sample and its coefficient; the
  // last cell takes the new sample when a sample transaction is accepted. While
  // rotating, each cell takes its upper neighbor's contents and the last cell
  // takes those of cell 0, so after TAPS steps every cell is back in place. The
  // shift step moves only the samples; the next sample overwrites the oldest.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    cell_ctrl_t                    cctrl;
    logic signed [SAMPLE_BITS-1:0] nb_coef, nb_left, nb_right;

    assign cctrl.coef_wr = coef_we && (32'(coef_index_i) == k);
    assign cctrl.coef_en = rotate || cctrl.coef_wr;

    if (k == TAPS - 1) begin : g_last
      assign cctrl.smp_en = rotate || hshift || load;
      assign nb_coef      = coef_w[0];
      assign nb_left      = load ? left_sample_i : left_w[0];
      assign nb_right     = load ? right_sample_i : right_w[0];
    end else begin : g_mid
      assign cctrl.smp_en = rotate || hshift;
      assign nb_coef      = coef_w[k+1];
      assign nb_left      = left_w[k+1];
      assign nb_right     = right_w[k+1];
    end

    sfg_tap_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cctrl),
      .wr_coef_i  (coef_value_i),
      .nb_coef_i  (nb_coef),
      .nb_left_i  (nb_left),
      .nb_right_i (nb_right),
      .coef_o     (coef_w[k]),
      .left_o     (left_w[k]),
      .right_o    (right_w[k])
    );
  end

  // ---------------------------------------------------------------------------
  // One arithmetic unit per channel, both fed from the head of the ring.
  // ---------------------------------------------------------------------------
  sfg_mac #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac_left (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .coef_i   (coef_w[0]),
    .sample_i (left_w[0]),
    .gain_i   (gain_q),
    .result_o (left_res)
  );

  sfg_mac #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac_right (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .coef_i   (coef_w[0]),
    .sample_i (right_w[0]),
    .gain_i   (gain_q),
    .result_o (right_res)
  );

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `include "stereo_fir_filter_with_gain_core_assert.svh"

  // An accepted sample transaction starts the rotation from step zero.
  `SFG_ASSERT_NEXT(a_sample_starts_mac, clk_i, rst_ni, load, (state_q == ST_MAC) && (cnt_q == '0))
  // The step counter is only in use while the ring rotates.
  `SFG_ASSERT_IMPL(a_cnt_idle_zero, clk_i, rst_ni, state_q != ST_MAC, cnt_q == '0)
  // A new result appears only when the sequencer finishes a sample transaction.
  `SFG_ASSERT_IMPL(a_result_from_done, clk_i, rst_ni, $rose(out_valid_o), $past(state_q) == ST_DONE)

endmodule

`default_nettype wire

>>> rtl/sfg_tap_cell.sv
// One tap cell: holds a coefficient and the left and right history samples.
`default_nettype none

module sfg_tap_cell
  import sfg_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cell_ctrl_t                    ctrl_i,
  input  wire logic signed [SAMPLE_BITS-1:0] wr_coef_i,
  input  wire logic signed [SAMPLE_BITS-1:0] nb_coef_i,
  input  wire logic signed [SAMPLE_BITS-1:0] nb_left_i,
  input  wire logic signed [SAMPLE_BITS-1:0] nb_right_i,
  output logic signed [SAMPLE_BITS-1:0]      coef_o,
  output logic signed [SAMPLE_BITS-1:0]      left_o,
  output logic signed [SAMPLE_BITS-1:0]      right_o
);

  logic signed [SAMPLE_BITS-1:0] coef_q, coef_d;
  logic signed [SAMPLE_BITS-1:0] left_q, right_q;

  // A direct write wins over the value handed in by the neighbor.
  assign coef_d = ctrl_i.coef_wr ? wr_coef_i : nb_coef_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q  <= '0;
      left_q  <= '0;
      right_q <= '0;
    end else begin
      if (ctrl_i.coef_en) begin
        coef_q <= coef_d;
      end
      if (ctrl_i.smp_en) begin
        left_q  <= nb_left_i;
        right_q <= nb_right_i;
      end
    end
  end

  assign coef_o  = coef_q;
  assign left_o  = left_q;
  assign right_o = right_q;

endmodule

`default_nettype wire

>>> rtl/sfg_mac.sv
// Per-channel multiply-accumulate, rounding, gain and saturation unit.
`default_nettype none

module sfg_mac
  import sfg_pkg::*;
#(
  parameter int TAPS        = TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire mac_ctrl_t                     ctrl_i,
  input  wire logic signed [SAMPLE_BITS-1:0] coef_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic        [GAIN_W-1:0]      gain_i,
  output logic signed [SAMPLE_BITS-1:0]      result_o
);

  localparam int AccW  = acc_width(SAMPLE_BITS, TAPS);
  localparam int ProdW = 2 * SAMPLE_BITS;
  localparam int MidW  = AccW - SAMPLE_BITS + 2;
  localparam int GpW   = MidW + GAIN_W + 1;
  localparam int QW    = GpW - GAIN_FRAC;

  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [AccW-1:0]  rnd_sum;
  logic signed [MidW-1:0]  mid_q, mid_d;
  logic signed [GpW-1:0]   gp_q, gp_d;
  logic signed [GpW-1:0]   gp_rnd;
  logic signed [QW-1:0]    q_val;
  logic                    ovf;

  always_comb begin
    prod_d  = ProdW'(coef_i) * ProdW'(sample_i);
    acc_d   = ctrl_i.acc_clr ? '0 : acc_q + AccW'(prod_q);
    // Round half up to sample scale before the gain stage.
    rnd_sum = acc_q + (AccW'(1) << (SAMPLE_BITS - 3));
    mid_d   = $signed(rnd_sum[AccW-1:SAMPLE_BITS-2]);
    gp_d    = GpW'(mid_q) * GpW'($signed({1'b0, gain_i}));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.acc_clr || ctrl_i.acc_en) begin
      acc_q <= acc_d;
    end
    if (ctrl_i.rnd_en) begin
      mid_q <= mid_d;
    end
    if (ctrl_i.gain_en) begin
      gp_q <= gp_d;
    end
  end

  // Second rounding drops the gain fraction, then the result saturates.
  always_comb begin
    gp_rnd = gp_q + (GpW'(1) << (GAIN_FRAC - 1));
    q_val  = $signed(gp_rnd[GpW-1:GAIN_FRAC]);
    ovf    = (q_val[QW-1:SAMPLE_BITS-1] != '0) && (q_val[QW-1:SAMPLE_BITS-1] != '1);
    if (!ovf) begin
      result_o = q_val[SAMPLE_BITS-1:0];
    end else if (q_val[QW-1]) begin
      result_o = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

>>> tb/stereo_fir_filter_with_gain_core_test.sv
// Self-checking testbench for the stereo FIR filter core with output gain.
`timescale 1ns / 1ps

module stereo_fir_filter_with_gain_core_test;
  import sfg_pkg::*;

  localparam int TAPS = TAPS_DEF;
  localparam int SB   = SAMPLE_BITS_DEF;

  // Register indexes of the configuration port. Index 1 holds no register, so
  // writes to it must leave the gain alone.
  localparam int REG_GAIN  = 0;
  localparam int REG_SPARE = 1;

  // Margin for anything still in flight inside the core once the last expected
  // result has arrived.
  localparam int SETTLE_CYCLES = TAPS + 15;
  localparam int LONG_STALL    = 400;
  localparam int PHASE_ITEMS   = 215;

  typedef logic signed [SB-1:0] sample_t;

  localparam sample_t S_MAX    = {1'b0, {(SB-1){1'b1}}};
  localparam sample_t S_MIN    = {1'b1, {(SB-1){1'b0}}};
  localparam sample_t COEF_ONE = {2'b01, {(SB-2){1'b0}}};

  typedef struct packed {
    logic                  op;
    logic [COEF_IDX_W-1:0] idx;
    sample_t               coef;
    sample_t               left;
    sample_t               right;
  } fir_txn_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } stereo_pair_t;

  // Clock, reset and all block inputs start at known values.
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic                  op_i           = OP_COEF;
  logic [COEF_IDX_W-1:0] coef_index_i   = '0;
  sample_t               coef_value_i   = '0;
  sample_t               left_sample_i  = '0;
  sample_t               right_sample_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  sample_t               left_out_o;
  sample_t               right_out_o;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [PADDR_W-1:0]    paddr          = '0;
  logic [PDATA_W-1:0]    pwdata         = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  // Input transactions waiting for the driver, and filtered pairs that the
  // core still owes us, oldest first.
  fir_txn_t     pending_txns[$];
  stereo_pair_t predicted_pairs[$];

  // Our own copy of the filter state: shared taps, one delay line per channel
  // (index 0 is the oldest sample) and the output gain.
  sample_t          coef_table[TAPS];
  sample_t          history[2][TAPS-1];
  logic [GAIN_W-1:0] gain_q313;

  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 76;
  int unsigned coef_shift    = 0;
  int unsigned mismatch_count = 0;

  // The stimulus process raises stall_request once; the monitor owns the count.
  logic stall_request = 1'b0;
  logic stall_taken   = 1'b0;
  int   stall_left    = 0;

  stereo_fir_filter_with_gain_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .coef_index_i   (coef_index_i),
    .coef_value_i   (coef_value_i),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin : clock_proc
    forever #5 clk_i = ~clk_i;
  end

  // One channel of the filter: the exact 64-bit sum of products, rounded half up
  // to sample scale, scaled by the Q3.13 gain, rounded again and saturated. The
  // new sample then enters the delay line.
  function automatic sample_t fir_channel_step(int ch, sample_t x);
    longint acc;
    longint mid;
    longint scaled;
    acc = longint'(coef_table[TAPS-1]) * longint'(x);
    for (int k = 0; k < TAPS - 1; k++)
      acc += longint'(coef_table[k]) * longint'(history[ch][k]);
    for (int k = 0; k < TAPS - 2; k++)
      history[ch][k] = history[ch][k+1];
    history[ch][TAPS-2] = x;
    mid = (acc + (longint'(1) <<< (SB - 3))) >>> (SB - 2);
    scaled = (mid * longint'(gain_q313) + (longint'(1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
    if (scaled > longint'(S_MAX))
      return S_MAX;
    if (scaled < longint'(S_MIN))
      return S_MIN;
    return sample_t'(scaled);
  endfunction

  // Applies one accepted transaction to our state. A coefficient write to a tap
  // beyond the table is dropped and, like any coefficient write, owes no result.
  function automatic void predict_txn(fir_txn_t t);
    stereo_pair_t pair;
    if (t.op == OP_COEF) begin
      if (t.idx < TAPS)
        coef_table[t.idx] = t.coef;
    end else begin
      pair.left  = fir_channel_step(0, t.left);
      pair.right = fir_channel_step(1, t.right);
      predicted_pairs.push_back(pair);
    end
  endfunction

  function automatic void report_mismatch(string what, sample_t want, sample_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endfunction

  // Mostly full-range values, with the extremes, the values around zero and
  // mid-sized values mixed in.
  function automatic sample_t pick_value();
    sample_t v;
    v = sample_t'($urandom);
    case ($urandom_range(9))
      0:       v = S_MAX;
      1:       v = S_MIN;
      2:       v = v >>> (SB - 2);
      3, 4:    v = v >>> 8;
      default: ;
    endcase
    return v;
  endfunction

  // Fields that the operation does not use are filled with noise, since the
  // core must ignore them.
  function automatic void queue_coef(int idx, sample_t value);
    fir_txn_t t;
    t.op    = OP_COEF;
    t.idx   = idx[COEF_IDX_W-1:0];
    t.coef  = value;
    t.left  = sample_t'($urandom);
    t.right = sample_t'($urandom);
    pending_txns.push_back(t);
  endfunction

  function automatic void queue_pair(sample_t left, sample_t right);
    fir_txn_t t;
    t.op    = OP_SAMPLE;
    t.idx   = COEF_IDX_W'($urandom);
    t.coef  = sample_t'($urandom);
    t.left  = left;
    t.right = right;
    pending_txns.push_back(t);
  endfunction

  // A random phase starts by reloading every tap at the phase's own scale, so some
  // phases filter without clipping and others clip hard. After that about one
  // transaction in five rewrites a tap, and a few of those aim past the table.
  task automatic run_filter_phase(int unsigned shift);
    sample_t value;
    coef_shift = shift;
    for (int k = 0; k < TAPS; k++)
      queue_coef(k, sample_t'($urandom) >>> shift);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if ($urandom_range(99) < 22) begin
        value = pick_value();
        if ($urandom_range(1) == 0)
          value = value >>> coef_shift;
        if ($urandom_range(9) == 0)
          queue_coef($urandom_range(31, TAPS), value);
        else
          queue_coef($urandom_range(TAPS - 1), value);
      end else begin
        queue_pair(pick_value(), pick_value());
      end
    end
    wait_idle();
  endtask

  // Returns once the driver has nothing left, every predicted pair has come
  // back, and the core has had time to finish a trailing coefficient write.
  task automatic wait_idle();
    while (pending_txns.size() != 0 || in_valid_i || predicted_pairs.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: a setup phase, then an access phase that completes at the first
  // edge with pready high. Only the low 16 bits of the gain register count.
  task automatic apb_write(int reg_idx, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * reg_idx);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_GAIN)
      gain_q313 = data[GAIN_W-1:0];
  endtask

  // Driver. At each edge it first books a transaction that the core took, then
  // either holds the current one or, unless it decides to idle, offers the next.
  // Valid gets exactly one assignment per edge, and the payload at most one.
  always @(posedge clk_i) begin : feed_proc
    logic accepted;
    logic offer;
    if (rst_ni) begin
      accepted = in_valid_i && in_ready_o;
      if (accepted)
        predict_txn(pending_txns.pop_front());
      offer = in_valid_i && !accepted;
      if (!offer && pending_txns.size() != 0 && $urandom_range(99) >= send_idle_pct)
        offer = 1'b1;
      if (offer) begin
        op_i           <= pending_txns[0].op;
        coef_index_i   <= pending_txns[0].idx;
        coef_value_i   <= pending_txns[0].coef;
        left_sample_i  <= pending_txns[0].left;
        right_sample_i <= pending_txns[0].right;
      end
      in_valid_i <= offer;
    end
  end

  // Monitor. Every result the core hands over is checked against the oldest
  // predicted pair. Ready is then chosen for the next edge: low throughout a
  // requested long hold-off, otherwise random at the current idle rate.
  always @(posedge clk_i) begin : capture_proc
    stereo_pair_t want;
    logic take;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (predicted_pairs.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with nothing outstanding, left %0d, right %0d",
                     $time, left_out_o, right_out_o);
        end else begin
          want = predicted_pairs.pop_front();
          if (left_out_o !== want.left)
            report_mismatch("left_out", want.left, left_out_o);
          if (right_out_o !== want.right)
            report_mismatch("right_out", want.right, right_out_o);
        end
      end
      if (stall_request && !stall_taken) begin
        stall_taken = 1'b1;
        stall_left  = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else begin
        take = $urandom_range(99) >= recv_idle_pct;
      end
      out_ready_i <= take;
    end
  end

  initial begin : stimulus_proc
    for (int k = 0; k < TAPS; k++)
      coef_table[k] = '0;
    for (int c = 0; c < 2; c++)
      for (int k = 0; k < TAPS - 1; k++)
        history[c][k] = '0;
    gain_q313 = GAIN_RESET;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. With all taps cleared by reset the first pair must come
    // back as zero. A full-scale last tap then drives both channels into
    // saturation, one each way. Writes to taps past the table must change
    // nothing, and a unity center tap with a tiny neighbor checks the rounding
    // of small values.
    queue_pair(S_MAX, S_MIN);
    queue_coef(TAPS - 1, S_MAX);
    queue_pair(S_MAX, S_MIN);
    queue_coef(0, S_MIN);
    queue_coef(TAPS, S_MAX);
    queue_coef(31, S_MIN);
    queue_pair('0, sample_t'(-1));
    queue_pair(sample_t'(1), S_MAX);
    queue_pair(S_MIN, '0);
    queue_coef(TAPS / 2, COEF_ONE);
    queue_coef(TAPS - 1, '0);
    queue_coef(0, '0);
    queue_coef(TAPS / 2 + 1, sample_t'(-1));
    queue_pair(sample_t'(-1), sample_t'(1));
    queue_pair(sample_t'(1), sample_t'(-1));
    queue_pair(S_MAX, S_MIN);
    queue_pair(S_MIN, S_MAX);
    queue_pair(pick_value(), pick_value());
    queue_pair(pick_value(), pick_value());
    queue_pair('0, '0);
    wait_idle();

    // Default unity gain, full-scale taps: heavy clipping.
    run_filter_phase(0);

    // Zero gain silences both channels whatever the taps hold.
    apb_write(REG_GAIN, '0);
    run_filter_phase(6);

    // Swap the idle rates and go to the largest gain the register can hold,
    // with noise in the unused upper data bits.
    send_idle_pct = 76;
    recv_idle_pct = 17;
    apb_write(REG_GAIN, {16'($urandom), 16'hFFFF});
    run_filter_phase(4);

    // A write to the unused register index must not disturb the gain.
    apb_write(REG_SPARE, $urandom);
    apb_write(REG_GAIN, 32'd32768);
    run_filter_phase(8);

    // No idling at all, and one long hold-off at the output so the core backs
    // up and stalls its input while the driver keeps offering.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apb_write(REG_GAIN, $urandom_range(65535));
    stall_request = 1'b1;
    run_filter_phase(3);

    apb_write(REG_GAIN, PDATA_W'(GAIN_RESET));
    run_filter_phase(5);

    if (mismatch_count == 0 && predicted_pairs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // A correct run needs well under a tenth of this.
  initial begin : watchdog_proc
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
